// ===== src/tdpt_pkg.sv =====
// shared types and constants for the trial division prime test
package tdpt_pkg;

  // first odd trial divisor and the step between divisors
  localparam int unsigned FIRST_DIVISOR = 3;
  localparam int unsigned DIVISOR_STEP  = 2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new value, reset divisor and square
    logic start_div;  // clear remainder, load dividend shifter
    logic step_div;   // one restoring remainder step
    logic next_div;   // advance to the next odd divisor
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic special;      // value decided without trial division
    logic special_val;  // result for the decided case
    logic bound_ok;     // divisor squared does not exceed value
    logic div_last;     // current step is the last remainder step
    logic rem_zero;     // remainder of the finished division is zero
  } status_t;

endpackage

// ===== src/tdpt_dpath.sv =====
// datapath: value, odd divisor, running square and bit-serial remainder unit
module tdpt_dpath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] value,
  input  tdpt_pkg::cmd_t         cmd,
  output tdpt_pkg::status_t      status
);

  // dividend bits below the sign bit
  localparam int NW = VALUE_WIDTH - 1;
  localparam int CW = $clog2(NW);
  localparam int SW = VALUE_WIDTH + 1;
  localparam logic [CW-1:0] LAST_STEP = CW'(NW - 1);
  localparam logic [VALUE_WIDTH-1:0] D_FIRST = VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
  localparam logic [VALUE_WIDTH-1:0] D_STEP  = VALUE_WIDTH'(tdpt_pkg::DIVISOR_STEP);
  localparam logic [SW-1:0] SQ_FIRST =
    SW'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
  localparam logic [SW-1:0] SQ_STEP_CONST =
    SW'(tdpt_pkg::DIVISOR_STEP * tdpt_pkg::DIVISOR_STEP);

  logic [VALUE_WIDTH-1:0] n_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic [SW-1:0]          sq_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [NW-1:0]          sh_r;
  logic [CW-1:0]          cnt_r;

  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   rem_diff;
  logic [VALUE_WIDTH-1:0] rem_nxt;
  logic [SW-1:0]          sq_nxt;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, sh_r[NW-1]};
    rem_diff = rem_sh - {1'b0, d_r};
    if (rem_sh >= {1'b0, d_r}) begin
      rem_nxt = rem_diff[VALUE_WIDTH-1:0];
    end else begin
      rem_nxt = rem_sh[VALUE_WIDTH-1:0];
    end
  end

  // (d+2)^2 = d^2 + 4d + 4
  assign sq_nxt = sq_r + {d_r[VALUE_WIDTH-2:0], 2'b00} + SQ_STEP_CONST;

  // registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r  <= value;
      d_r  <= D_FIRST;
      sq_r <= SQ_FIRST;
    end else if (cmd.next_div) begin
      d_r  <= d_r + D_STEP;
      sq_r <= sq_nxt;
    end
    if (cmd.start_div) begin
      rem_r <= '0;
      sh_r  <= n_r[NW-1:0];
      cnt_r <= '0;
    end else if (cmd.step_div) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[NW-2:0], 1'b0};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // status: negative, zero and one are not prime, two is, other evens are not
  always_comb begin
    status.special     = 1'b0;
    status.special_val = 1'b0;
    if (n_r[VALUE_WIDTH-1] || (n_r[VALUE_WIDTH-1:1] == '0)) begin
      status.special = 1'b1;
    end else if (n_r == VALUE_WIDTH'(2)) begin
      status.special     = 1'b1;
      status.special_val = 1'b1;
    end else if (!n_r[0]) begin
      status.special = 1'b1;
    end
    status.bound_ok = sq_r <= {1'b0, n_r};
    status.div_last = cnt_r == LAST_STEP;
    status.rem_zero = rem_r == '0;
  end

endmodule

// ===== src/tdpt_ctrl.sv =====
// controller: sequences the trial divisions and holds the result register
module tdpt_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_is_prime,
  input  tdpt_pkg::status_t       status,
  output tdpt_pkg::cmd_t          cmd
);

  tdpt_pkg::state_t state_r, state_nxt;
  logic res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_is_prime_r, out_is_prime_nxt;
  logic accept;
  logic out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tdpt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tdpt_pkg::ST_CHECK;
      end
      tdpt_pkg::ST_CHECK: begin
        if (status.special || !status.bound_ok) begin
          state_nxt = tdpt_pkg::ST_FINISH;
        end else begin
          state_nxt = tdpt_pkg::ST_DIV;
        end
      end
      tdpt_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = tdpt_pkg::ST_EVAL;
      end
      tdpt_pkg::ST_EVAL: begin
        if (status.rem_zero) begin
          state_nxt = tdpt_pkg::ST_FINISH;
        end else begin
          state_nxt = tdpt_pkg::ST_CHECK;
        end
      end
      tdpt_pkg::ST_FINISH: begin
        if (out_free) state_nxt = tdpt_pkg::ST_IDLE;
      end
      default: state_nxt = tdpt_pkg::ST_IDLE;
    endcase
  end

  // outputs and result bookkeeping
  always_comb begin
    cmd              = '0;
    in_stall         = 1'b1;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_is_prime_nxt = out_is_prime_r;
    unique case (state_r)
      tdpt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      tdpt_pkg::ST_CHECK: begin
        if (status.special) begin
          res_nxt = status.special_val;
        end else if (!status.bound_ok) begin
          res_nxt = 1'b1;
        end else begin
          cmd.start_div = 1'b1;
        end
      end
      tdpt_pkg::ST_DIV: begin
        cmd.step_div = 1'b1;
      end
      tdpt_pkg::ST_EVAL: begin
        if (status.rem_zero) begin
          res_nxt = 1'b0;
        end else begin
          cmd.next_div = 1'b1;
        end
      end
      tdpt_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_r          <= res_nxt;
    out_is_prime_r <= out_is_prime_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // an accepted transaction starts the bound check next cycle
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == tdpt_pkg::ST_CHECK)
    else $error("accepted transaction did not start checking");

  // a new result only comes out of the finish state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && out_stall)) |-> state_r == tdpt_pkg::ST_FINISH)
    else $error("result loaded outside finish state");

  // a finished result waits while the output is blocked
  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tdpt_pkg::ST_FINISH && out_valid_r && out_stall)
      |=> state_r == tdpt_pkg::ST_FINISH)
    else $error("finished result dropped while output blocked");

  // input side only open while idle
  a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tdpt_pkg::ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");

endmodule

// ===== src/trial_division_prime_test.sv =====
// top level of the trial division prime test
//
// Tests one signed integer per transaction and returns one flag that is 1 when
// it is prime. Negative values, 0, 1 and all even values, 2 included, are
// answered without trial division. Odd values try the odd divisors from 3 upward
// while the divisor squared stays at or below the value; each divisor is
// tested by the bit-serial remainder unit that takes one dividend bit per
// cycle. One value is worked on at a time; a finished result sits in an
// output register, and the next value is accepted as soon as the result has
// been handed over or placed in that register.
module trial_division_prime_test #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_prime
);

  tdpt_pkg::cmd_t    cmd;
  tdpt_pkg::status_t status;

  // sequencing and result register
  tdpt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime),
    .status       (status),
    .cmd          (cmd)
  );

  // divisor, square and remainder datapath
  tdpt_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk    (clk),
    .value  (in_value),
    .cmd    (cmd),
    .status (status)
  );

endmodule

// ===== test/testbench.sv =====
// testbench for trial_division_prime_test: directed corners, random values, scoreboard check
`timescale 1ns / 1ps

module testbench;

  localparam int VW = 32;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int NUM_CORNERS = 22;
  localparam int ITEMS_PER_PHASE = 20;

  // predicts the prime flag of each accepted value and checks the returned flags
  class prime_scoreboard;
    bit expected_flags[$];
    int failures;

    function bit predict_prime(logic [VW-1:0] value);
      longint unsigned n;
      longint unsigned d;
      n = 64'(value);
      // sign bit set, zero and one are never prime
      if (value[VW-1]) return 1'b0;
      if (n <= 1) return 1'b0;
      if (n == 2) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      // odd divisors while d*d <= n, written so it cannot overflow
      for (d = 3; d <= n / d; d += 2) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_value(logic [VW-1:0] value);
      expected_flags.push_back(predict_prime(value));
    endfunction

    function void check_flag(logic actual);
      bit want;
      if (expected_flags.size() == 0) begin
        $error("is_prime: unexpected result, expected none, actual %0b", actual);
        failures++;
        return;
      end
      want = expected_flags.pop_front();
      if (actual !== want) begin
        $error("is_prime: expected %0b, actual %0b", want, actual);
        failures++;
      end
    endfunction
  endclass

  // corner values: sign extremes, small specials, squares of primes, top of range
  localparam logic [VW-1:0] CORNER_VALUES [NUM_CORNERS] = '{
    32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFD,
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15,
    32'd25, 32'd49, 32'd97, 32'd121, 32'd63001, 32'd65521,
    32'd1000003, 32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h7FFF_FFFF
  };

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [VW-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_is_prime;

  prime_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  trial_division_prime_test #(.VALUE_WIDTH(VW)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watch both channels for completed transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_value(in_value);
      if (out_valid && !out_stall) sb.check_flag(out_is_prime);
    end
  end

  // random value, weighted toward cases that finish quickly
  function automatic logic [VW-1:0] random_value();
    int unsigned pick;
    int unsigned p;
    int unsigned m;
    logic [VW-1:0] v;
    pick = $urandom_range(9);
    if (pick <= 3) begin
      v = $urandom_range(1023);
    end else if (pick <= 5) begin
      v = $urandom_range(65535, 1025) | 32'd1;
    end else if (pick == 6) begin
      v = $urandom | 32'h8000_0000;
    end else if (pick == 7) begin
      v = $urandom & 32'h7FFF_FFFE;
    end else begin
      // odd multiple of a small prime, mostly a large composite
      case ($urandom_range(4))
        0: p = 3;
        1: p = 5;
        2: p = 7;
        3: p = 11;
        default: p = 13;
      endcase
      m = $urandom_range(32'h7FFF_FFFF / p - 1, 1);
      v = p * m;
      if (!v[0]) v = v + p;
    end
    return v;
  endfunction

  // offer one transaction, with a random gap before it
  task automatic send_value(input logic [VW-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender off until every expected flag has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_flags.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_value(random_value());
    pause_until_drained();
  endtask

  // main sequence
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners with no idling
    for (int i = 0; i < NUM_CORNERS; i++) send_value(CORNER_VALUES[i]);
    pause_until_drained();

    // random phases with different idling and receiver stall patterns
    run_phase(0, 0, ITEMS_PER_PHASE);
    run_phase(85, 0, ITEMS_PER_PHASE);
    run_phase(0, 85, ITEMS_PER_PHASE);
    run_phase(6, 6, ITEMS_PER_PHASE);

    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== trial_division_prime_test.f =====
src/tdpt_pkg.sv
src/tdpt_dpath.sv
src/tdpt_ctrl.sv
src/trial_division_prime_test.sv
test/testbench.sv
